FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define MLFQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition must never be true out of reset
`define MLFQ_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

FILE: hdl/mlfq_pkg.sv
// ----------------------------------------------------------------------------
// mlfq_pkg
// Types, codes and reset values shared by the feedback scheduler modules.
// ----------------------------------------------------------------------------
package mlfq_pkg;

	// request codes
	localparam logic [2:0] RQ_ADMIT    = 3'd0;
	localparam logic [2:0] RQ_YIELD    = 3'd1;
	localparam logic [2:0] RQ_SLEEP    = 3'd2;
	localparam logic [2:0] RQ_WAKE     = 3'd3;
	localparam logic [2:0] RQ_RELEASE  = 3'd4;
	localparam logic [2:0] RQ_SCHEDULE = 3'd5;

	// entry states
	localparam logic [1:0] ES_UNUSED   = 2'd0;
	localparam logic [1:0] ES_RUNNABLE = 2'd1;
	localparam logic [1:0] ES_RUNNING  = 2'd2;
	localparam logic [1:0] ES_SLEEPING = 2'd3;

	// result codes
	localparam logic [1:0] RES_OK   = 2'd0;
	localparam logic [1:0] RES_NONE = 2'd1;
	localparam logic [1:0] RES_BAD  = 2'd2;

	// levels and tick limit
	localparam logic [1:0] LVL_TOP    = 2'd0;
	localparam logic [1:0] LVL_LOWEST = 2'd3;
	localparam logic [7:0] TICK_MAX   = 8'd255;

	// register map (word index) and reset values
	localparam int         APB_AW       = 4;
	localparam logic [1:0] CFG_QUOTA0   = 2'd0;
	localparam logic [1:0] CFG_QUOTA1   = 2'd1;
	localparam logic [1:0] CFG_QUOTA2   = 2'd2;
	localparam logic [1:0] CFG_STARVE   = 2'd3;
	localparam logic [7:0]  QUOTA0_RST  = 8'd5;
	localparam logic [7:0]  QUOTA1_RST  = 8'd5;
	localparam logic [7:0]  QUOTA2_RST  = 8'd10;
	localparam logic [15:0] STARVE_RST  = 16'd100;

	typedef struct packed {
		logic [7:0]  quota0;
		logic [7:0]  quota1;
		logic [7:0]  quota2;
		logic [15:0] starve_limit;
	} cfg_t;

	// one table word
	typedef struct packed {
		logic [1:0] status;
		logic [1:0] level;
		logic [7:0] ticks;
	} entry_word_t;

	// table write controls
	typedef struct packed {
		logic        en;
		logic        stamp_en;
		entry_word_t word;
		logic [31:0] stamp;
	} tbl_wr_t;

	// shared compare unit operands: (a + b) < c
	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
	} alu_op_t;

	typedef struct packed {
		logic [1:0] status;
		logic [5:0] chosen;
		logic [1:0] level;
	} result_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOK,
		S_EXEC,
		S_SCAN,
		S_FINISH
	} state_t;

endpackage

FILE: hdl/mlfq_table.sv
// ----------------------------------------------------------------------------
// mlfq_table
// Entry table: state word and grant time memories, one read and one write
// port each, registered read; per-entry valid bits give the reset contents.
// ----------------------------------------------------------------------------
module mlfq_table import mlfq_pkg::*; #(
	parameter int ENTRIES = 64,
	localparam int IW = $clog2(ENTRIES)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [IW-1:0] rd_addr,
	output entry_word_t   rd_word,
	output logic [31:0]   rd_stamp,
	input  logic [IW-1:0] wr_addr,
	input  tbl_wr_t       wr
);

	entry_word_t        word_mem [ENTRIES];
	logic [31:0]        stamp_mem [ENTRIES];
	entry_word_t        word_rd_q;
	logic [31:0]        stamp_rd_q;
	logic [ENTRIES-1:0] vld_q;
	logic               rd_vld_q;

	// memory arrays, read data registered
	always_ff @(posedge clk) begin
		if (wr.en) begin
			word_mem[wr_addr] <= wr.word;
		end
		if (wr.stamp_en) begin
			stamp_mem[wr_addr] <= wr.stamp;
		end
		word_rd_q  <= word_mem[rd_addr];
		stamp_rd_q <= stamp_mem[rd_addr];
	end

	// valid bits: an entry never written reads its state word as all zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			rd_vld_q <= vld_q[rd_addr];
		end
	end

	assign rd_word  = rd_vld_q ? word_rd_q : '0;
	assign rd_stamp = stamp_rd_q;

endmodule

FILE: hdl/mlfq_alu.sv
// ----------------------------------------------------------------------------
// mlfq_alu
// Shared add-and-compare unit: starvation age test and quota test.
// ----------------------------------------------------------------------------
module mlfq_alu import mlfq_pkg::*; (
	input  alu_op_t op,
	output logic    lt
);

	logic [32:0] sum;

	// 33-bit sum so the age test never wraps
	assign sum = {1'b0, op.a} + {1'b0, op.b};
	assign lt  = sum < {1'b0, op.c};

endmodule

FILE: hdl/mlfq_ctrl.sv
// ----------------------------------------------------------------------------
// mlfq_ctrl
// Request sequencer: single-entry updates, table scans for admit and
// schedule, and the result register toward the output channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mlfq_ctrl import mlfq_pkg::*; #(
	parameter int ENTRIES = 64,
	localparam int IW = $clog2(ENTRIES)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cfg_t          cfg,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [2:0]    req_type,
	input  logic [5:0]    entry,
	input  logic [31:0]   now,
	output logic          out_valid,
	input  logic          out_stall,
	output result_t       out_res,
	output logic [IW-1:0] rd_addr,
	input  entry_word_t   rd_word,
	input  logic [31:0]   rd_stamp,
	output logic [IW-1:0] wr_addr,
	output tbl_wr_t       tbl_wr,
	output alu_op_t       alu_op,
	input  logic          alu_lt
);

	localparam int CNT_W = IW + 1;

	state_t          state_q, state_d;
	logic [2:0]      req_q;
	logic [5:0]      entry_q;
	logic [31:0]     now_q;
	logic [CNT_W-1:0] cnt_q;
	logic            pend_s1;
	logic [IW-1:0]   pidx_s1;
	logic            found_q;
	logic [IW-1:0]   best_idx_q;
	logic [1:0]      best_lvl_q;
	logic [7:0]      best_ticks_q;
	result_t         res_q;
	logic            out_valid_q;
	result_t         out_res_q;

	logic            in_acc;
	logic            scan_req;
	logic            in_range;
	logic            scan_issue;
	logic            scan_done;
	logic            admit_hit;
	logic            out_free;
	logic [IW-1:0]   e_idx;
	logic            res_load;
	result_t         res_next;
	logic            cand;
	logic [1:0]      lvl_new;

	assign in_acc     = in_valid && !in_stall;
	assign scan_req   = (req_type == RQ_ADMIT) || (req_type == RQ_SCHEDULE);
	assign in_range   = 32'(entry) < 32'(ENTRIES);
	assign scan_issue = cnt_q < CNT_W'(ENTRIES);
	assign scan_done  = !scan_issue && !pend_s1;
	assign admit_hit  = pend_s1 && (req_q == RQ_ADMIT) && (rd_word.status == ES_UNUSED);
	assign out_free   = !out_valid_q || !out_stall;
	assign e_idx      = IW'(entry_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					if (scan_req) begin
						state_d = S_SCAN;
					end else if (!in_range) begin
						state_d = S_FINISH;
					end else begin
						state_d = S_LOOK;
					end
				end
			end
			S_LOOK: state_d = S_EXEC;
			S_EXEC: state_d = S_FINISH;
			S_SCAN: begin
				if (admit_hit || scan_done) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// datapath controls and result
	always_comb begin
		logic [7:0] t_new;
		logic [7:0] quota_sel;
		logic       raise;
		in_stall   = (state_q != S_IDLE);
		rd_addr    = '0;
		wr_addr    = '0;
		tbl_wr     = '0;
		alu_op     = '0;
		res_load   = 1'b0;
		res_next   = '0;
		cand       = 1'b0;
		lvl_new    = rd_word.level;
		raise      = 1'b0;
		t_new      = (rd_word.ticks == TICK_MAX) ? TICK_MAX : rd_word.ticks + 8'd1;
		case (rd_word.level)
			2'd0:    quota_sel = cfg.quota0;
			2'd1:    quota_sel = cfg.quota1;
			default: quota_sel = cfg.quota2;
		endcase
		tbl_wr.stamp = now_q;
		unique case (state_q)
			S_IDLE: begin
				// out-of-range entry: answered without a table access
				if (in_acc && !scan_req && !in_range) begin
					res_load        = 1'b1;
					res_next.status = RES_BAD;
					res_next.chosen = entry;
					res_next.level  = LVL_TOP;
				end
			end
			S_LOOK: begin
				rd_addr = e_idx;
			end
			S_EXEC: begin
				rd_addr         = e_idx;
				wr_addr         = e_idx;
				alu_op.a        = 32'(quota_sel);
				alu_op.c        = 32'(t_new) + 32'd1;
				res_load        = 1'b1;
				res_next.status = RES_BAD;
				res_next.chosen = entry_q;
				res_next.level  = rd_word.level;
				tbl_wr.word     = rd_word;
				unique case (req_q)
					RQ_YIELD: begin
						if (rd_word.status == ES_RUNNING) begin
							tbl_wr.en          = 1'b1;
							tbl_wr.word.status = ES_RUNNABLE;
							// quota reached: demote and clear the count
							if (rd_word.level != LVL_LOWEST && alu_lt) begin
								tbl_wr.word.level = rd_word.level + 2'd1;
								tbl_wr.word.ticks = 8'd0;
							end else begin
								tbl_wr.word.ticks = t_new;
							end
							res_next.status = RES_OK;
							res_next.level  = tbl_wr.word.level;
						end
					end
					RQ_SLEEP: begin
						if (rd_word.status == ES_RUNNING) begin
							tbl_wr.en          = 1'b1;
							tbl_wr.word.status = ES_SLEEPING;
							res_next.status    = RES_OK;
						end
					end
					RQ_WAKE: begin
						if (rd_word.status == ES_SLEEPING) begin
							tbl_wr.en          = 1'b1;
							tbl_wr.word.status = ES_RUNNABLE;
							res_next.status    = RES_OK;
						end
					end
					RQ_RELEASE: begin
						if (rd_word.status != ES_UNUSED) begin
							tbl_wr.en       = 1'b1;
							tbl_wr.word     = '0;
							res_next.status = RES_OK;
							res_next.level  = LVL_TOP;
						end
					end
					default: ;
				endcase
			end
			S_SCAN: begin
				rd_addr  = scan_issue ? cnt_q[IW-1:0] : '0;
				wr_addr  = pidx_s1;
				alu_op.a = rd_stamp;
				alu_op.b = 32'(cfg.starve_limit);
				alu_op.c = now_q;
				if (pend_s1) begin
					if (req_q == RQ_ADMIT) begin
						// first unused entry taken at the top level
						if (admit_hit) begin
							tbl_wr.en          = 1'b1;
							tbl_wr.word.status = ES_RUNNABLE;
							res_load           = 1'b1;
							res_next.status    = RES_OK;
							res_next.chosen    = 6'(pidx_s1);
							res_next.level     = LVL_TOP;
						end
					end else begin
						// age raise, then track best level / lowest index
						raise   = (rd_word.status == ES_RUNNABLE) &&
							(rd_word.level != LVL_TOP) && alu_lt;
						lvl_new = raise ? rd_word.level - 2'd1 : rd_word.level;
						if (raise) begin
							tbl_wr.en         = 1'b1;
							tbl_wr.word       = rd_word;
							tbl_wr.word.level = lvl_new;
						end
						cand = (rd_word.status == ES_RUNNABLE) &&
							(!found_q || lvl_new < best_lvl_q);
					end
				end else if (!scan_issue) begin
					res_load        = 1'b1;
					res_next.status = RES_NONE;
					if (req_q == RQ_SCHEDULE && found_q) begin
						// grant: mark running and stamp the time
						wr_addr            = best_idx_q;
						tbl_wr.en          = 1'b1;
						tbl_wr.stamp_en    = 1'b1;
						tbl_wr.word.status = ES_RUNNING;
						tbl_wr.word.level  = best_lvl_q;
						tbl_wr.word.ticks  = best_ticks_q;
						res_next.status    = RES_OK;
						res_next.chosen    = 6'(best_idx_q);
						res_next.level     = best_lvl_q;
					end
				end
			end
			S_FINISH: ;
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			pend_s1     <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				cnt_q   <= '0;
				pend_s1 <= 1'b0;
				found_q <= 1'b0;
			end else if (state_q == S_SCAN) begin
				if (scan_issue) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
				pend_s1 <= scan_issue;
				if (cand) begin
					found_q <= 1'b1;
				end
			end
			if (state_q == S_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_q   <= req_type;
			entry_q <= entry;
			now_q   <= now;
		end
		if (state_q == S_SCAN && scan_issue) begin
			pidx_s1 <= cnt_q[IW-1:0];
		end
		if (cand) begin
			best_idx_q   <= pidx_s1;
			best_lvl_q   <= lvl_new;
			best_ticks_q <= rd_word.ticks;
		end
		if (res_load) begin
			res_q <= res_next;
		end
		if (state_q == S_FINISH && out_free) begin
			out_res_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	// checks
	`MLFQ_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(ENTRIES), "scan counter past table end")
	`MLFQ_ASSERT(a_busy_after_acc, in_acc |=> (state_q != S_IDLE), "idle right after accept")
	`MLFQ_ASSERT(a_finish_exit, (state_q == S_FINISH) |=> (state_q == S_FINISH || state_q == S_IDLE), "bad exit from finish")
	`MLFQ_ASSERT(a_grant_found, tbl_wr.stamp_en |-> (found_q && tbl_wr.word.status == ES_RUNNING), "grant without candidate")

endmodule

FILE: hdl/mlfq_process_scheduler.sv
// ----------------------------------------------------------------------------
// mlfq_process_scheduler
// Four-level feedback scheduler over an entry table, with APB registers.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_stall (req_type, entry, now); one result
//   transaction per request leaves on out_valid/out_stall (status,
//   chosen_entry, level). A transaction moves when valid is high and stall
//   is low. in_stall is high while a request is in progress.
//   Yield, sleep, wake, release: the request passes through the look,
//   execute and finish states; an out-of-range entry goes straight to finish.
//   Admit and schedule scan the table one entry per cycle through the
//   single table read port (admit stops early at the first free entry).
//   The age test and quota test share one add-and-compare unit.
//   The next request is taken the cycle after the result is loaded into
//   the output register; a stalled receiver holds the result and keeps the
//   block waiting with it.
//   Reset clears the table through per-entry valid bits at once; no
//   clearing pass is needed. Registers reset to quotas 5, 5, 10 and a
//   starvation limit of 100; write them only while idle.
// ----------------------------------------------------------------------------
module mlfq_process_scheduler import mlfq_pkg::*; #(
	parameter int ENTRIES = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	// request channel
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [2:0]        req_type,
	input  logic [5:0]        entry,
	input  logic [31:0]       now,
	// result channel
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        status,
	output logic [5:0]        chosen_entry,
	output logic [1:0]        level,
	// configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int IW = $clog2(ENTRIES);

	cfg_t          cfg_q;
	logic          cfg_wr;
	logic [IW-1:0] rd_addr;
	logic [IW-1:0] wr_addr;
	entry_word_t   rd_word;
	logic [31:0]   rd_stamp;
	tbl_wr_t       tbl_wr;
	alu_op_t       alu_op;
	logic          alu_lt;
	result_t       out_res;

	// register writes
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.quota0       <= QUOTA0_RST;
			cfg_q.quota1       <= QUOTA1_RST;
			cfg_q.quota2       <= QUOTA2_RST;
			cfg_q.starve_limit <= STARVE_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				CFG_QUOTA0: cfg_q.quota0       <= pwdata[7:0];
				CFG_QUOTA1: cfg_q.quota1       <= pwdata[7:0];
				CFG_QUOTA2: cfg_q.quota2       <= pwdata[7:0];
				CFG_STARVE: cfg_q.starve_limit <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		unique case (paddr[3:2])
			CFG_QUOTA0: prdata = 32'(cfg_q.quota0);
			CFG_QUOTA1: prdata = 32'(cfg_q.quota1);
			CFG_QUOTA2: prdata = 32'(cfg_q.quota2);
			CFG_STARVE: prdata = 32'(cfg_q.starve_limit);
			default:    prdata = '0;
		endcase
	end

	mlfq_table #(.ENTRIES(ENTRIES)) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_addr  (rd_addr),
		.rd_word  (rd_word),
		.rd_stamp (rd_stamp),
		.wr_addr  (wr_addr),
		.wr       (tbl_wr)
	);

	mlfq_alu u_alu (
		.op (alu_op),
		.lt (alu_lt)
	);

	mlfq_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.entry     (entry),
		.now       (now),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res),
		.rd_addr   (rd_addr),
		.rd_word   (rd_word),
		.rd_stamp  (rd_stamp),
		.wr_addr   (wr_addr),
		.tbl_wr    (tbl_wr),
		.alu_op    (alu_op),
		.alu_lt    (alu_lt)
	);

	assign status       = out_res.status;
	assign chosen_entry = out_res.chosen;
	assign level        = out_res.level;

endmodule

FILE: tb/tb_mlfq_process_scheduler.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mlfq_process_scheduler
// Self-checking bench for the four-level feedback scheduler. A scoreboard
// keeps its own copy of the entry table and quotas, predicts the answer to
// every accepted request and compares it field by field with each result.
// Stimulus is a directed opener, then phases of state-aware random requests
// under several register settings, with random gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_mlfq_process_scheduler;
	import mlfq_pkg::*;

	localparam int N_ENTRIES   = 64;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int LONG_HOLD   = 400;
	localparam int SHOW_ERRORS = 10;

	// request codes the block does not define
	localparam logic [2:0] RQ_UNDEF_6 = 3'd6;
	localparam logic [2:0] RQ_UNDEF_7 = 3'd7;

	// scoreboard: shadow table plus queue of owed answers
	class sched_scoreboard;
		logic [1:0]  ent_state [N_ENTRIES];
		logic [1:0]  ent_level [N_ENTRIES];
		logic [7:0]  ent_ticks [N_ENTRIES];
		logic [31:0] run_stamp [N_ENTRIES];
		logic [7:0]  quota [3];
		logic [15:0] starve_limit;
		result_t     owed[$];
		int n_errors, n_checked, n_grants, n_raises, n_demotes, n_none;

		function new();
			for (int i = 0; i < N_ENTRIES; i++) begin
				ent_state[i] = ES_UNUSED;
				ent_level[i] = LVL_TOP;
				ent_ticks[i] = '0;
				run_stamp[i] = '0;
			end
			quota[0] = QUOTA0_RST;
			quota[1] = QUOTA1_RST;
			quota[2] = QUOTA2_RST;
			starve_limit = STARVE_RST;
		endfunction

		function void set_reg(logic [1:0] idx, logic [31:0] val);
			case (idx)
				CFG_QUOTA0: quota[0] = val[7:0];
				CFG_QUOTA1: quota[1] = val[7:0];
				CFG_QUOTA2: quota[2] = val[7:0];
				CFG_STARVE: starve_limit = val[15:0];
				default: ;
			endcase
		endfunction

		function int count_in_state(logic [1:0] s);
			int n;
			n = 0;
			for (int i = 0; i < N_ENTRIES; i++)
				if (ent_state[i] == s) n++;
			return n;
		endfunction

		// random entry in state s, -1 if there is none
		function int pick_in_state(logic [1:0] s);
			int n, k;
			n = count_in_state(s);
			if (n == 0) return -1;
			k = $urandom_range(0, n - 1);
			for (int i = 0; i < N_ENTRIES; i++) begin
				if (ent_state[i] == s) begin
					if (k == 0) return i;
					k--;
				end
			end
			return -1;
		endfunction

		// update the shadow table and queue the answer for one request
		function void note_request(logic [2:0] req, logic [5:0] e, logic [31:0] t);
			result_t r;
			bit found;
			r = '0;
			found = 0;
			case (req)
				RQ_ADMIT: begin
					for (int i = 0; i < N_ENTRIES; i++) begin
						if (!found && ent_state[i] == ES_UNUSED) begin
							ent_state[i] = ES_RUNNABLE;
							ent_level[i] = LVL_TOP;
							ent_ticks[i] = '0;
							r.status = RES_OK;
							r.chosen = i[5:0];
							r.level = LVL_TOP;
							found = 1;
						end
					end
					if (!found) begin
						r.status = RES_NONE;
						n_none++;
					end
				end
				RQ_SCHEDULE: begin
					// aging pass, compare done without wraparound
					for (int i = 0; i < N_ENTRIES; i++) begin
						if (ent_state[i] == ES_RUNNABLE && ent_level[i] != LVL_TOP &&
							({1'b0, run_stamp[i]} + {17'd0, starve_limit}) < {1'b0, t}) begin
							ent_level[i] = ent_level[i] - 2'd1;
							n_raises++;
						end
					end
					// best level first, lowest index within a level
					for (int l = 0; l < 4; l++) begin
						for (int i = 0; i < N_ENTRIES; i++) begin
							if (!found && ent_state[i] == ES_RUNNABLE &&
								int'(ent_level[i]) == l) begin
								ent_state[i] = ES_RUNNING;
								run_stamp[i] = t;
								r.status = RES_OK;
								r.chosen = i[5:0];
								r.level = ent_level[i];
								found = 1;
								n_grants++;
							end
						end
					end
					if (!found) begin
						r.status = RES_NONE;
						n_none++;
					end
				end
				default: begin
					r.chosen = e;
					if (int'(e) >= N_ENTRIES) begin
						r.status = RES_BAD;
					end else begin
						r.status = RES_BAD;
						r.level = ent_level[e];
						if (req == RQ_YIELD && ent_state[e] == ES_RUNNING) begin
							ent_state[e] = ES_RUNNABLE;
							if (ent_ticks[e] != TICK_MAX) ent_ticks[e] = ent_ticks[e] + 8'd1;
							if (ent_level[e] != LVL_LOWEST &&
								ent_ticks[e] >= quota[ent_level[e]]) begin
								ent_level[e] = ent_level[e] + 2'd1;
								ent_ticks[e] = '0;
								n_demotes++;
							end
							r.status = RES_OK;
							r.level = ent_level[e];
						end else if (req == RQ_SLEEP && ent_state[e] == ES_RUNNING) begin
							ent_state[e] = ES_SLEEPING;
							r.status = RES_OK;
						end else if (req == RQ_WAKE && ent_state[e] == ES_SLEEPING) begin
							ent_state[e] = ES_RUNNABLE;
							r.status = RES_OK;
						end else if (req == RQ_RELEASE && ent_state[e] != ES_UNUSED) begin
							ent_state[e] = ES_UNUSED;
							ent_level[e] = LVL_TOP;
							ent_ticks[e] = '0;
							r.status = RES_OK;
							r.level = LVL_TOP;
						end
					end
				end
			endcase
			owed.push_back(r);
		endfunction

		function void check_result(logic [1:0] st, logic [5:0] ch, logic [1:0] lv);
			result_t want;
			n_checked++;
			if (owed.size() == 0) begin
				n_errors++;
				if (n_errors <= SHOW_ERRORS)
					$display("%0t: result with nothing owed: status %0d entry %0d level %0d",
						$time, st, ch, lv);
				return;
			end
			want = owed.pop_front();
			if (want.status !== st || want.chosen !== ch || want.level !== lv) begin
				n_errors++;
				if (n_errors <= SHOW_ERRORS)
					$display("%0t: mismatch: expected status %0d entry %0d level %0d, %s %0d %0d %0d",
						$time, want.status, want.chosen, want.level, "got", st, ch, lv);
			end
		endfunction
	endclass

	// block ports; the inputs are all known from time zero
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] req_type = RQ_ADMIT;
	logic [5:0] entry = '0;
	logic [31:0] now = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] status;
	logic [5:0] chosen_entry;
	logic [1:0] level;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	sched_scoreboard sb;
	bit quiet = 0;
	int hold_requests = 0;
	int holds_done = 0;
	int stall_left = 0;
	int cycle_count = 0;
	int n_sent = 0;
	logic [31:0] sim_now = '0;

	mlfq_process_scheduler #(.ENTRIES(N_ENTRIES)) uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .entry(entry), .now(now),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .chosen_entry(chosen_entry), .level(level),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #6 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still owed",
				cycle_count, sb.owed.size());
			$display("** mlfq_process_scheduler: FAILED **");
			$finish;
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(status, chosen_entry, level);
	end

	// receiver: random stalls, plus long hold-offs on request
	always @(posedge clk) begin
		if (holds_done < hold_requests) begin
			holds_done++;
			stall_left = LONG_HOLD;
		end
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (quiet || $urandom_range(0, 99) < 65) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= 1'b1;
			stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(8, 60);
		end
	end

	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	// mostly advancing time, scaled to the starvation limit, with wild jumps
	function automatic logic [31:0] next_time();
		int r;
		r = $urandom_range(0, 99);
		if (r < 6) return $urandom;
		if (r < 8) return 32'hFFFF_FFFF - $urandom_range(0, 70000);
		sim_now = sim_now + $urandom_range(0, sb.starve_limit / 8 + 16);
		return sim_now;
	endfunction

	// one transaction on the request side; returns at the accepting edge
	task automatic send_request(input logic [2:0] req, input logic [5:0] e, input logic [31:0] t);
		int gap;
		bit taken;
		gap = quiet ? 0 : draw_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_type <= req;
		entry <= e;
		now <= t;
		in_valid <= 1'b1;
		taken = 0;
		while (!taken) begin
			@(posedge clk);
			taken = !in_stall;
		end
		sb.note_request(req, e, t);
		n_sent++;
	endtask

	task automatic wait_all_answered();
		in_valid <= 1'b0;
		while (sb.owed.size() > 0) @(posedge clk);
		@(posedge clk);
	endtask

	// setup cycle, then access cycle; the write lands at the end of the access cycle
	task automatic write_register(input logic [1:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_reg(idx, val);
	endtask

	task automatic set_all_regs(input int q0, input int q1, input int q2, input int lim);
		write_register(CFG_QUOTA0, q0);
		write_register(CFG_QUOTA1, q1);
		write_register(CFG_QUOTA2, q2);
		write_register(CFG_STARVE, lim);
	endtask

	// state-aware random requests; target is the table occupancy aimed at
	task automatic run_mixed_phase(input int n_items, input int target, input bit with_hold);
		int r, pick, used;
		logic [2:0] req;
		logic [5:0] e;
		for (int k = 0; k < n_items; k++) begin
			if (with_hold && k == 30) hold_requests++;
			if ($urandom_range(0, 99) == 0) wait_all_answered();
			r = $urandom_range(0, 99);
			used = N_ENTRIES - sb.count_in_state(ES_UNUSED);
			pick = -1;
			if (r < 14 && used < target) begin
				req = RQ_ADMIT;
			end else if (r < 14 || (r >= 80 && r < 88)) begin
				req = RQ_RELEASE;
				case ($urandom_range(0, 2))
					0: pick = sb.pick_in_state(ES_RUNNABLE);
					1: pick = sb.pick_in_state(ES_RUNNING);
					default: pick = sb.pick_in_state(ES_SLEEPING);
				endcase
			end else if (r < 40) begin
				req = RQ_SCHEDULE;
			end else if (r < 62) begin
				req = RQ_YIELD;
				pick = sb.pick_in_state(ES_RUNNING);
			end else if (r < 70) begin
				req = RQ_SLEEP;
				pick = sb.pick_in_state(ES_RUNNING);
			end else if (r < 80) begin
				req = RQ_WAKE;
				pick = sb.pick_in_state(ES_SLEEPING);
			end else begin
				// noise: any code, any entry
				req = 3'($urandom_range(0, 7));
			end
			e = (pick >= 0) ? pick[5:0] : 6'($urandom_range(0, 63));
			send_request(req, e, next_time());
		end
		wait_all_answered();
	endtask

	initial begin
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed opener at reset register values
		send_request(RQ_SCHEDULE, 6'd0, 32'd0);
		send_request(RQ_YIELD, 6'd0, 32'd0);
		send_request(RQ_SLEEP, 6'd63, 32'd0);
		send_request(RQ_WAKE, 6'd5, 32'd0);
		send_request(RQ_RELEASE, 6'd0, 32'd0);
		send_request(RQ_ADMIT, 6'd63, 32'd0);
		send_request(RQ_ADMIT, 6'd0, 32'd0);
		send_request(RQ_ADMIT, 6'd0, 32'd0);
		send_request(RQ_SCHEDULE, 6'd0, 32'd0);
		send_request(RQ_SCHEDULE, 6'd63, 32'd10);
		send_request(RQ_YIELD, 6'd0, 32'd0);
		send_request(RQ_SLEEP, 6'd1, 32'd0);
		send_request(RQ_WAKE, 6'd1, 32'd0);
		send_request(RQ_WAKE, 6'd1, 32'd0);
		send_request(RQ_RELEASE, 6'd2, 32'd0);
		send_request(RQ_RELEASE, 6'd2, 32'd0);
		send_request(RQ_UNDEF_6, 6'd0, 32'd0);
		send_request(RQ_UNDEF_7, 6'd63, 32'hFFFF_FFFF);
		send_request(RQ_SCHEDULE, 6'd0, 32'hFFFF_FFFF);
		send_request(RQ_SCHEDULE, 6'd0, 32'hFFFF_FFFF);
		wait_all_answered();

		// reset settings, with a long receiver hold-off
		run_mixed_phase(160, 8, 1);

		// zero level-0 quota demotes on the first yield; no starvation slack
		set_all_regs(0, 255, 1, 0);
		run_mixed_phase(160, 12, 0);

		// one entry walked down to the lowest level until its ticks saturate
		quiet = 1;
		set_all_regs(1, 1, 1, 65535);
		for (int i = 0; i < N_ENTRIES; i++)
			if (sb.ent_state[i] != ES_UNUSED) send_request(RQ_RELEASE, i[5:0], 32'd0);
		send_request(RQ_ADMIT, 6'd0, 32'd0);
		for (int k = 0; k < 262; k++) begin
			send_request(RQ_SCHEDULE, 6'd0, k * 2);
			send_request(RQ_YIELD, 6'd0, 32'd0);
		end
		wait_all_answered();
		quiet = 0;

		// largest settings with the table filled past full
		set_all_regs(255, 255, 255, 65535);
		for (int k = 0; k <= N_ENTRIES; k++)
			send_request(RQ_ADMIT, 6'($urandom_range(0, 63)), next_time());
		run_mixed_phase(160, N_ENTRIES, 0);

		// small quotas and short starvation limit, first without idling
		set_all_regs(1, 2, 3, 20);
		quiet = 1;
		run_mixed_phase(80, 6, 0);
		quiet = 0;
		run_mixed_phase(80, 6, 0);

		// random settings, second long hold-off
		set_all_regs($urandom_range(1, 255), $urandom_range(1, 255),
			$urandom_range(1, 255), $urandom_range(0, 2000));
		run_mixed_phase(160, $urandom_range(2, 40), 1);

		// drain and finish
		repeat (10) @(posedge clk);
		if (sb.owed.size() > 0) begin
			$display("%0d results never arrived", sb.owed.size());
			sb.n_errors += sb.owed.size();
		end
		$display("covered %0d requests and %0d results: %0d grants, %0d raises, %0d demotions",
			n_sent, sb.n_checked, sb.n_grants, sb.n_raises, sb.n_demotes);
		$display("%0d no-entry answers, %0d mismatches, %0d cycles",
			sb.n_none, sb.n_errors, cycle_count);
		if (sb.n_errors == 0) begin
			$display("** mlfq_process_scheduler: PASSED **");
		end else begin
			$display("** mlfq_process_scheduler: FAILED **");
		end
		$finish;
	end

endmodule
